### hw/rtl/gea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gea_pkg: shared types and constants of the generational entity allocator
// Request and response payloads, operation and status codes, and the
// command/status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package gea_pkg;

    localparam int SLOT_MAX = 1024;
    localparam int SLOT_W   = $clog2(SLOT_MAX);
    localparam int CNT_W    = SLOT_W + 1;
    localparam int GEN_W    = 16;
    localparam int IDX_W    = 10;
    localparam int VER_W    = 16;
    localparam int LIVE_W   = 10;

    typedef enum logic [1:0] {
        KIND_CREATE  = 2'd0,
        KIND_DESTROY = 2'd1,
        KIND_FLUSH   = 2'd2,
        KIND_CHECK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_DEAD = 2'd2
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   target_index;
        logic [VER_W-1:0]   target_version;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]   handle_index;
        logic [VER_W-1:0]   handle_version;
        status_t            status;
        logic               alive;
        logic [LIVE_W-1:0]  live_total;
    } rsp_t;

    typedef struct packed {
        logic               used;
        logic [GEN_W-1:0]   gen;
    } slot_word_t;

    typedef struct packed {
        logic lookup;
        logic eval;
        logic slot_read;
        logic destroy;
        logic create_commit;
        logic flush_read;
        logic flush_write;
        logic finish;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  alive;
        logic  free_avail;
        logic  fresh_avail;
        logic  pend_empty;
        logic  flush_last;
        logic  out_free;
    } sts_t;

endpackage

### hw/rtl/generational_entity_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_entity_allocator_top: generational entity handle allocator
// Creates, destroys and checks slot/generation handles; destroyed slots wait
// on a pending list until a flush moves them onto the free stack.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   req_valid / req_ready  req_data (gea_pkg::req_t)
//  response  rsp_valid / rsp_ready  rsp_data (gea_pkg::rsp_t)
//
//  Create steps through table read, slot read, commit and response load;
//  destroy and check skip the slot read and commit.
//  Flush alternates a pending-list read and a free-stack write for each
//  pending slot, then loads the response.
//  No clearing pass after reset: the reserved slot and slots at or above the
//  fresh-slot mark read as zero.
//  A response held by rsp_ready stalls the next request at its response load.
// ----------------------------------------------------------------------------
module generational_entity_allocator_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  gea_pkg::req_t  req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output gea_pkg::rsp_t  rsp_data
);

    gea_pkg::cmd_t cmd;
    gea_pkg::sts_t sts;

    gea_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gea_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

### hw/rtl/gea_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gea_ctrl: allocator sequencer
// Steps each request through lookup, evaluation, create commit or flush walk,
// and response load, driving the datapath by commands.
// ----------------------------------------------------------------------------
module gea_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  gea_pkg::sts_t sts,
    output gea_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CREATE,
        S_FLUSH_RD,
        S_FLUSH_WR,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.lookup = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_FINISH;
                case (sts.kind)
                    gea_pkg::KIND_CREATE:
                    begin
                        if (sts.free_avail || sts.fresh_avail)
                        begin
                            cmd.slot_read = 1'b1;
                            state_next    = S_CREATE;
                        end
                    end
                    gea_pkg::KIND_DESTROY:
                    begin
                        cmd.destroy = sts.alive;
                    end
                    gea_pkg::KIND_FLUSH:
                    begin
                        if (!sts.pend_empty)
                        begin
                            state_next = S_FLUSH_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_CREATE:
            begin
                cmd.create_commit = 1'b1;
                state_next        = S_FINISH;
            end
            S_FLUSH_RD:
            begin
                cmd.flush_read = 1'b1;
                state_next     = S_FLUSH_WR;
            end
            S_FLUSH_WR:
            begin
                cmd.flush_write = 1'b1;
                state_next      = sts.flush_last ? S_FINISH : S_FLUSH_RD;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/gea_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gea_dp: allocator datapath
// Generation table, free stack and pending list memories, the depth and
// fill counters, and the response register.
// ----------------------------------------------------------------------------
module gea_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  gea_pkg::req_t  req_data,
    input  gea_pkg::cmd_t  cmd,
    output gea_pkg::sts_t  sts,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output gea_pkg::rsp_t  rsp_data
);

    gea_pkg::slot_word_t          gen_mem [gea_pkg::SLOT_MAX];
    logic [gea_pkg::SLOT_W-1:0]   free_mem [gea_pkg::SLOT_MAX];
    logic [gea_pkg::SLOT_W-1:0]   pend_mem [gea_pkg::SLOT_MAX];

    gea_pkg::req_t                req_reg;
    gea_pkg::slot_word_t          gen_rd_reg;
    logic [gea_pkg::SLOT_W-1:0]   gen_rd_addr_reg;
    logic [gea_pkg::SLOT_W-1:0]   free_rd_reg;
    logic [gea_pkg::SLOT_W-1:0]   pend_rd_reg;
    logic [gea_pkg::CNT_W-1:0]    free_depth_reg;
    logic [gea_pkg::CNT_W-1:0]    pend_depth_reg;
    logic [gea_pkg::CNT_W-1:0]    fresh_reg;
    logic [gea_pkg::CNT_W-1:0]    flush_ptr_reg;
    logic [gea_pkg::LIVE_W-1:0]   live_reg;
    logic [gea_pkg::SLOT_W-1:0]   slot_reg;
    logic                         src_free_reg;
    logic                         created_reg;
    logic                         alive_reg;
    logic [gea_pkg::GEN_W-1:0]    cur_gen_reg;
    logic                         out_valid_reg;
    gea_pkg::rsp_t                out_reg;

    gea_pkg::slot_word_t          gen_view;
    logic                         alive;
    logic [gea_pkg::CNT_W-1:0]    free_top;
    logic [gea_pkg::CNT_W-1:0]    flush_ptr_inc;
    logic [gea_pkg::SLOT_W-1:0]   slot_pick;
    logic [gea_pkg::SLOT_W-1:0]   gen_rd_addr;
    logic                         gen_rd_en;
    logic                         gen_wr_en;
    logic [gea_pkg::SLOT_W-1:0]   gen_wr_addr;
    gea_pkg::slot_word_t          gen_wr_data;
    logic [gea_pkg::GEN_W-1:0]    gen_bump;
    gea_pkg::status_t             status_code;

    // the reserved slot and slots at or above the fill mark are never written
    // and read as zero
    assign gen_view = ((gen_rd_addr_reg == '0)
                       || ({1'b0, gen_rd_addr_reg} >= fresh_reg)) ? '0 : gen_rd_reg;
    assign alive    = (req_reg.target_index != '0) && gen_view.used
                      && (gen_view.gen == req_reg.target_version);
    assign gen_bump = gen_view.gen + 1'b1;

    assign free_top      = free_depth_reg - 1'b1;
    assign flush_ptr_inc = flush_ptr_reg + 1'b1;
    assign slot_pick     = (free_depth_reg != '0) ? free_rd_reg
                                                  : fresh_reg[gea_pkg::SLOT_W-1:0];

    assign gen_rd_en   = cmd.lookup || cmd.slot_read;
    assign gen_rd_addr = cmd.lookup ? req_data.target_index : slot_pick;

    always_comb
    begin
        gen_wr_en   = 1'b0;
        gen_wr_addr = req_reg.target_index;
        gen_wr_data = '{used: 1'b0, gen: gen_bump};
        if (cmd.destroy)
        begin
            gen_wr_en = 1'b1;
        end
        else if (cmd.create_commit)
        begin
            gen_wr_en   = 1'b1;
            gen_wr_addr = slot_reg;
            gen_wr_data = '{used: 1'b1, gen: gen_view.gen};
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen_wr_en)
        begin
            gen_mem[gen_wr_addr] <= gen_wr_data;
        end
        if (gen_rd_en)
        begin
            gen_rd_reg      <= gen_mem[gen_rd_addr];
            gen_rd_addr_reg <= gen_rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.flush_write)
        begin
            free_mem[free_depth_reg[gea_pkg::SLOT_W-1:0]] <= pend_rd_reg;
        end
        if (cmd.lookup)
        begin
            free_rd_reg <= free_mem[free_top[gea_pkg::SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.destroy)
        begin
            pend_mem[pend_depth_reg[gea_pkg::SLOT_W-1:0]] <= req_reg.target_index;
        end
        if (cmd.flush_read)
        begin
            pend_rd_reg <= pend_mem[flush_ptr_reg[gea_pkg::SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_depth_reg <= '0;
            pend_depth_reg <= '0;
            fresh_reg      <= gea_pkg::CNT_W'(1);
            flush_ptr_reg  <= '0;
            live_reg       <= '0;
        end
        else
        begin
            if (cmd.destroy)
            begin
                pend_depth_reg <= pend_depth_reg + 1'b1;
                live_reg       <= live_reg - 1'b1;
            end
            if (cmd.create_commit)
            begin
                live_reg <= live_reg + 1'b1;
                if (src_free_reg)
                begin
                    free_depth_reg <= free_top;
                end
                else
                begin
                    fresh_reg <= fresh_reg + 1'b1;
                end
            end
            if (cmd.flush_write)
            begin
                free_depth_reg <= free_depth_reg + 1'b1;
                if (flush_ptr_inc == pend_depth_reg)
                begin
                    flush_ptr_reg  <= '0;
                    pend_depth_reg <= '0;
                end
                else
                begin
                    flush_ptr_reg <= flush_ptr_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            req_reg     <= req_data;
            created_reg <= 1'b0;
        end
        if (cmd.eval)
        begin
            alive_reg   <= alive;
            cur_gen_reg <= cmd.destroy ? gen_bump : gen_view.gen;
        end
        if (cmd.slot_read)
        begin
            slot_reg     <= slot_pick;
            src_free_reg <= (free_depth_reg != '0);
        end
        if (cmd.create_commit)
        begin
            created_reg <= 1'b1;
            cur_gen_reg <= gen_view.gen;
        end
    end

    always_comb
    begin
        case (req_reg.kind)
            gea_pkg::KIND_CREATE:
                status_code = created_reg ? gea_pkg::STAT_OK : gea_pkg::STAT_FULL;
            gea_pkg::KIND_DESTROY,
            gea_pkg::KIND_CHECK:
                status_code = alive_reg ? gea_pkg::STAT_OK : gea_pkg::STAT_DEAD;
            default:
                status_code = gea_pkg::STAT_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.handle_index   <= created_reg ? slot_reg : req_reg.target_index;
            out_reg.handle_version <= cur_gen_reg;
            out_reg.status         <= status_code;
            out_reg.alive          <= alive_reg;
            out_reg.live_total     <= live_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    assign sts.kind        = req_reg.kind;
    assign sts.alive       = alive;
    assign sts.free_avail  = (free_depth_reg != '0);
    assign sts.fresh_avail = (fresh_reg < gea_pkg::CNT_W'(gea_pkg::SLOT_MAX));
    assign sts.pend_empty  = (pend_depth_reg == '0);
    assign sts.flush_last  = (flush_ptr_inc == pend_depth_reg);
    assign sts.out_free    = !out_valid_reg || rsp_ready;

endmodule

### hw/rtl/gea_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gea_checker: port-level checks of the allocator
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module gea_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  gea_pkg::rsp_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    a_dead_not_alive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == gea_pkg::STAT_DEAD) |-> !rsp_data.alive)
        else $error("dead status on a live handle");

    a_alive_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.alive |-> rsp_data.handle_index != '0)
        else $error("reserved slot reported alive");

endmodule

bind generational_entity_allocator_top gea_checker u_gea_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

### bench/tb_generational_entity_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generational_entity_allocator_top: self-checking bench for the allocator
// Runs a directed sequence, then random create/destroy/check traffic that
// fills every slot until the block reports full, then drains it with flushes.
// A local allocator model predicts every response in request order, and a
// monitor compares each response field by field against the oldest
// prediction. Both sides idle at random, including one long response stall.
// ----------------------------------------------------------------------------
module tb_generational_entity_allocator_top;

    localparam int RANDOM_ITEMS   = 1750;
    localparam int MIN_DRAIN      = 300;
    localparam int LONG_STALL     = 400;
    localparam int STALL_AT       = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        gea_pkg::req_t req;
        bit            drain_first;
    } queued_req_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    gea_pkg::req_t  req_data  = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    gea_pkg::rsp_t  rsp_data;

    // allocator model state
    bit [gea_pkg::GEN_W-1:0]  slot_gen [gea_pkg::SLOT_MAX];
    bit                       slot_used [gea_pkg::SLOT_MAX];
    bit [gea_pkg::SLOT_W-1:0] free_stack [gea_pkg::SLOT_MAX];
    bit [gea_pkg::SLOT_W-1:0] pending_slots [gea_pkg::SLOT_MAX];
    int                       free_depth    = 0;
    int                       pending_depth = 0;
    int                       next_fresh    = 1;
    int                       live_count    = 0;

    // stimulus bookkeeping
    logic [gea_pkg::IDX_W-1:0]                 live_slots [$];
    logic [gea_pkg::IDX_W+gea_pkg::VER_W-1:0]  retired_handles [$];
    int                                        full_hits = 0;

    queued_req_t    request_queue [$];
    gea_pkg::rsp_t  precomputed_handles [$];
    gea_pkg::rsp_t  awaited_handles [$];

    int requests_sent  = 0;
    int results_seen   = 0;
    int send_gap       = 0;
    int recv_gap       = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    generational_entity_allocator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic gea_pkg::rsp_t predict_handle_result(gea_pkg::req_t rq);
        gea_pkg::rsp_t              rs;
        logic                       was_alive;
        logic                       created;
        logic [gea_pkg::SLOT_W-1:0] slot;
        int                         i;
        was_alive = (rq.target_index != 0) && slot_used[rq.target_index]
                    && (slot_gen[rq.target_index] == rq.target_version);
        rs.handle_index = rq.target_index;
        rs.status       = gea_pkg::STAT_OK;
        rs.alive        = was_alive;
        created         = 1'b0;
        slot            = '0;
        case (rq.kind)
            gea_pkg::KIND_CREATE:
            begin
                if (free_depth > 0)
                begin
                    free_depth--;
                    slot    = free_stack[free_depth];
                    created = (slot != 0);
                end
                else if (next_fresh < gea_pkg::SLOT_MAX)
                begin
                    slot    = next_fresh[gea_pkg::SLOT_W-1:0];
                    next_fresh++;
                    created = 1'b1;
                end
                if (created)
                begin
                    slot_used[slot] = 1'b1;
                    live_count++;
                    rs.handle_index = slot;
                end
                else
                    rs.status = gea_pkg::STAT_FULL;
            end
            gea_pkg::KIND_DESTROY:
            begin
                if (was_alive)
                begin
                    slot_gen[rq.target_index]  = slot_gen[rq.target_index] + 1'b1;
                    slot_used[rq.target_index] = 1'b0;
                    live_count--;
                    pending_slots[pending_depth] = rq.target_index;
                    pending_depth++;
                end
                else
                    rs.status = gea_pkg::STAT_DEAD;
            end
            gea_pkg::KIND_FLUSH:
            begin
                for (i = 0; i < pending_depth; i++)
                begin
                    free_stack[free_depth] = pending_slots[i];
                    free_depth++;
                end
                pending_depth = 0;
            end
            default:
            begin
                if (!was_alive)
                    rs.status = gea_pkg::STAT_DEAD;
            end
        endcase
        rs.handle_version = slot_gen[rs.handle_index];
        rs.live_total     = live_count[gea_pkg::LIVE_W-1:0];
        return rs;
    endfunction

    task automatic queue_request(gea_pkg::kind_t k, logic [gea_pkg::IDX_W-1:0] idx,
                                 logic [gea_pkg::VER_W-1:0] ver, bit drain);
        queued_req_t                               q;
        gea_pkg::rsp_t                             rs;
        logic [gea_pkg::IDX_W+gea_pkg::VER_W-1:0]  tag;
        int                                        i;
        q.req.kind           = k;
        q.req.target_index   = idx;
        q.req.target_version = ver;
        q.drain_first        = drain;
        rs = predict_handle_result(q.req);
        request_queue       = {request_queue, q};
        precomputed_handles = {precomputed_handles, rs};
        if (k == gea_pkg::KIND_CREATE && rs.status == gea_pkg::STAT_OK)
            live_slots = {live_slots, rs.handle_index};
        if (rs.status == gea_pkg::STAT_FULL)
            full_hits++;
        if (k == gea_pkg::KIND_DESTROY && rs.status == gea_pkg::STAT_OK)
        begin
            for (i = 0; i < live_slots.size(); i++)
            begin
                if (live_slots[i] == idx)
                begin
                    live_slots.delete(i);
                    break;
                end
            end
            tag             = {idx, ver};
            retired_handles = {retired_handles, tag};
            if (retired_handles.size() > 32)
                void'(retired_handles.pop_front());
        end
    endtask

    task automatic queue_random(gea_pkg::kind_t k, bit drain);
        int                        r;
        logic [gea_pkg::IDX_W-1:0] idx;
        logic [gea_pkg::VER_W-1:0] ver;
        r   = $urandom_range(0, 99);
        idx = gea_pkg::IDX_W'($urandom);
        ver = gea_pkg::VER_W'($urandom);
        if (r < 70 && live_slots.size() > 0)
        begin
            idx = live_slots[$urandom_range(0, live_slots.size() - 1)];
            ver = slot_gen[idx];
        end
        else if (r < 80 && retired_handles.size() > 0)
            {idx, ver} = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
        else if (r < 88 && live_slots.size() > 0)
        begin
            idx = live_slots[$urandom_range(0, live_slots.size() - 1)];
            ver = slot_gen[idx] ^ (16'd1 << $urandom_range(0, gea_pkg::VER_W - 1));
        end
        queue_request(k, idx, ver, drain);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        bit offering;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end
        else
        begin
            offering = req_valid;
            if (req_valid && req_ready)
            begin
                awaited_handles = {awaited_handles, precomputed_handles.pop_front()};
                requests_sent++;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (request_queue.size() > 0
                         && !(request_queue[0].drain_first && awaited_handles.size() > 0))
                begin
                    req_data <= request_queue.pop_front().req;
                    offering = 1'b1;
                    if ((requests_sent / 128) % 4 == 3 || $urandom_range(0, 1) == 0)
                        send_gap = 0;
                    else
                        send_gap = $urandom_range(0, 17);
                end
            end
            req_valid <= offering;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : response_monitor
        gea_pkg::rsp_t want;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                results_seen++;
                if (awaited_handles.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected response: idx=%0d ver=%0d",
                                 rsp_data.handle_index, rsp_data.handle_version,
                                 " status=%0d alive=%0d live=%0d",
                                 rsp_data.status, rsp_data.alive, rsp_data.live_total);
                end
                else
                begin
                    want = awaited_handles.pop_front();
                    if (rsp_data !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("response %0d mismatch: expected idx=%0d ver=%0d",
                                     results_seen, want.handle_index, want.handle_version,
                                     " status=%0d alive=%0d live=%0d,",
                                     want.status, want.alive, want.live_total,
                                     " got idx=%0d ver=%0d",
                                     rsp_data.handle_index, rsp_data.handle_version,
                                     " status=%0d alive=%0d live=%0d",
                                     rsp_data.status, rsp_data.alive, rsp_data.live_total);
                    end
                end
                if (results_seen == STALL_AT)
                    recv_gap = LONG_STALL;
                else if ((results_seen / 128) % 4 == 1 || $urandom_range(0, 1) == 0)
                    recv_gap = 0;
                else
                    recv_gap = $urandom_range(0, 17);
                rsp_ready <= (recv_gap == 0);
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_ready <= (recv_gap == 0);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int n;
        int r;
        int fill_items;

        queue_request(gea_pkg::KIND_CHECK,   10'd0,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_DESTROY, 10'd0,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_CHECK,   10'd1023, 16'hFFFF, 1'b0);
        queue_request(gea_pkg::KIND_FLUSH,   10'd0,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_CREATE,  10'd0,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_CREATE,  10'd1023, 16'hFFFF, 1'b0);
        queue_request(gea_pkg::KIND_CREATE,  10'd1,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_CHECK,   10'd2,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_CHECK,   10'd2,    16'd1,    1'b0);
        queue_request(gea_pkg::KIND_CHECK,   10'd5,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_DESTROY, 10'd2,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_DESTROY, 10'd2,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_CHECK,   10'd2,    16'd1,    1'b0);
        queue_request(gea_pkg::KIND_CREATE,  10'd2,    16'd1,    1'b0);
        queue_request(gea_pkg::KIND_DESTROY, 10'd1,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_DESTROY, 10'd3,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_FLUSH,   10'd3,    16'd1,    1'b0);
        queue_request(gea_pkg::KIND_CREATE,  10'd0,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_CREATE,  10'd3,    16'd1,    1'b0);
        queue_request(gea_pkg::KIND_CREATE,  10'd1023, 16'hFFFF, 1'b0);
        queue_request(gea_pkg::KIND_CREATE,  10'd0,    16'd0,    1'b0);
        queue_request(gea_pkg::KIND_DESTROY, 10'd4,    16'hFFFF, 1'b0);
        queue_request(gea_pkg::KIND_FLUSH,   10'd0,    16'd0,    1'b0);

        n = 0;
        while (full_hits < 3 && n < 3000)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
                queue_random(gea_pkg::KIND_CREATE, n == 900);
            else if (r < 95)
                queue_random(gea_pkg::KIND_CHECK, n == 900);
            else
                queue_random(gea_pkg::KIND_DESTROY, n == 900);
            n++;
        end
        fill_items = n;
        while (n < RANDOM_ITEMS || n < fill_items + MIN_DRAIN)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                queue_random(gea_pkg::KIND_DESTROY, n == fill_items);
            else if (r < 65)
                queue_random(gea_pkg::KIND_CREATE, n == fill_items);
            else if (r < 85)
                queue_random(gea_pkg::KIND_CHECK, n == fill_items);
            else
                queue_random(gea_pkg::KIND_FLUSH, n == fill_items);
            n++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() > 0 || req_valid || awaited_handles.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_handles.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/gea_pkg.sv
hw/rtl/gea_ctrl.sv
hw/rtl/gea_dp.sv
hw/rtl/generational_entity_allocator_top.sv
hw/rtl/gea_checker.sv
bench/tb_generational_entity_allocator_top.sv
